### hdl/pup_pkg.sv
// Shared types, codes and constants for the palette upscale packer.
// Used by pup_addr, pup_seq and the top level; depends on nothing.
package pup_pkg;

    // Item field widths
    localparam int CMD_W     = 2;
    localparam int IDX_W     = 8;
    localparam int CH_W      = 8;
    localparam int COLOR_W   = 24;
    localparam int PX_W      = 9;
    localparam int PV_W      = 8;
    localparam int ROW_W     = 8;
    localparam int REP_W     = 3;
    localparam int OW_W      = 9;
    localparam int DATA_W    = 64;
    localparam int ADDR_W    = 22;
    localparam int LANE_W    = 2;
    localparam int RGB565_W  = 16;

    // Stream and configuration port widths
    localparam int S_TDATA_W = 72;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 88;
    localparam int M_TUSER_W = 3;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 16;
    localparam int STRIDE_W  = 16;
    localparam int ROWS_W    = 8;

    // Pixel counter width (up to four pixels in one half word)
    localparam int PC_W      = 3;

    // Command codes carried in s_tuser
    localparam logic [CMD_W-1:0] CMD_PAL_WR  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LINE_WR = 2'd1;
    localparam logic [CMD_W-1:0] CMD_EMIT    = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FORMAT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STRIDE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS   = 2'd2;

    // Pixel formats
    localparam logic FMT_XRGB8888 = 1'b0;
    localparam logic FMT_RGB565   = 1'b1;

    // Pixels per half word
    localparam logic [PC_W-1:0] PPH_XRGB = 3'd2;
    localparam logic [PC_W-1:0] PPH_565  = 3'd4;

    // Channel masks for RGB565 reduction
    localparam logic [CH_W-1:0] MASK_R5 = 8'hF8;
    localparam logic [CH_W-1:0] MASK_G6 = 8'hFC;

    typedef struct packed {
        logic                fmt;
        logic [STRIDE_W-1:0] stride_bytes;
        logic [ROWS_W-1:0]   rows_in_use;
    } cfg_t;

    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic [IDX_W-1:0] entry_index;
        logic [CH_W-1:0]  red;
        logic [CH_W-1:0]  green;
        logic [CH_W-1:0]  blue;
        logic [PX_W-1:0]  pixel_x;
        logic [PV_W-1:0]  pixel_value;
        logic [ROW_W-1:0] src_row;
        logic [REP_W-1:0] rep_row;
        logic [OW_W-1:0]  out_word;
        logic             half_select;
    } in_item_t;

    typedef struct packed {
        logic             start;
        logic             fmt;
        logic [ROW_W-1:0] src_row;
        logic [REP_W-1:0] rep_row;
        logic [OW_W-1:0]  out_word;
    } emit_req_t;

    // Reduce an RGB888 palette color to RGB565
    function automatic logic [RGB565_W-1:0] to_rgb565(input logic [COLOR_W-1:0] c);
        logic [CH_W-1:0] r_m;
        logic [CH_W-1:0] g_m;
        logic [CH_W-1:0] b_m;
        r_m = c[23:16] & MASK_R5;
        g_m = c[15:8] & MASK_G6;
        b_m = c[7:0] & MASK_R5;
        return {r_m[7:3], g_m[7:2], b_m[7:3]};
    endfunction

endpackage

### hdl/pup_ram.sv
// Simple dual-port synchronous RAM, one write and one registered read port.
// Holds the palette and the line store; no package dependency.
module pup_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 24,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### hdl/pup_addr.sv
// Word address and lane computation for one emit request, two register stages.
// Depends on pup_pkg.
module pup_addr #(
    parameter int SRC_WIDTH = 320,
    parameter int SCALE     = 5
) (
    input  logic                         clk,
    input  pup_pkg::emit_req_t           req,
    input  logic [pup_pkg::STRIDE_W-1:0] stride_bytes,
    output logic [pup_pkg::ADDR_W-1:0]   word_address,
    output logic [pup_pkg::LANE_W-1:0]   lane
);

    localparam int RW888 = (SRC_WIDTH * SCALE + 3) / 4;
    localparam int RW565 = (SRC_WIDTH * SCALE + 7) / 8;
    localparam int LW888 = (RW888 + 3) / 4;
    localparam int LW565 = (RW565 + 3) / 4;
    localparam int RW_W  = $clog2(RW888 + 1);
    localparam int CW    = ((RW_W > pup_pkg::OW_W) ? RW_W : pup_pkg::OW_W) + 1;
    localparam int SW_W  = (RW_W > 13) ? RW_W : 13;
    localparam int RI_W  = $clog2(256 * SCALE);
    localparam int PW    = RI_W + SW_W;
    localparam int SUM_W = (PW + 1 > pup_pkg::ADDR_W) ? PW + 1 : pup_pkg::ADDR_W;

    logic [RI_W-1:0]             ri_reg,   ri_next;
    logic [SW_W-1:0]             sw_reg,   sw_next;
    logic [pup_pkg::OW_W-1:0]    ow_reg,   ow_next;
    logic [pup_pkg::LANE_W-1:0]  lane_reg, lane_next;
    logic [pup_pkg::ADDR_W-1:0]  addr_reg, addr_next;

    logic [16:0]     sw_sum;
    logic [12:0]     sw_raw;
    logic [SW_W-1:0] rw_cur;
    logic [CW-1:0]   ow_ext;
    logic [CW-1:0]   lw;
    logic [PW-1:0]   prod;
    logic [SUM_W-1:0] sum;

    always_comb
    begin
        sw_sum = 17'(stride_bytes) + 17'd15;
        sw_raw = sw_sum[16:4];
        rw_cur = req.fmt ? SW_W'(RW565) : SW_W'(RW888);
        ow_ext = CW'(req.out_word);
        lw     = req.fmt ? CW'(LW565) : CW'(LW888);

        ri_next   = ri_reg;
        sw_next   = sw_reg;
        ow_next   = ow_reg;
        lane_next = lane_reg;
        if (req.start)
        begin
            ri_next = RI_W'(RI_W'(req.src_row) * RI_W'(SCALE)) + RI_W'(req.rep_row);
            if (stride_bytes == '0 || SW_W'(sw_raw) < rw_cur)
            begin
                sw_next = rw_cur;
            end
            else
            begin
                sw_next = SW_W'(sw_raw);
            end
            ow_next = req.out_word;
            // Quarter of the row; the last lane absorbs any remainder
            if (ow_ext >= CW'(3 * lw))
            begin
                lane_next = 2'd3;
            end
            else if (ow_ext >= CW'(2 * lw))
            begin
                lane_next = 2'd2;
            end
            else if (ow_ext >= lw)
            begin
                lane_next = 2'd1;
            end
            else
            begin
                lane_next = 2'd0;
            end
        end

        prod      = PW'(ri_reg) * PW'(sw_reg);
        sum       = SUM_W'(prod) + SUM_W'(ow_reg);
        addr_next = sum[pup_pkg::ADDR_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        ri_reg   <= ri_next;
        sw_reg   <= sw_next;
        ow_reg   <= ow_next;
        lane_reg <= lane_next;
        addr_reg <= addr_next;
    end

    assign word_address = addr_reg;
    assign lane         = lane_reg;

endmodule

### hdl/pup_seq.sv
// Input decode, memory access sequencing, pixel packing and output register.
// Depends on pup_pkg; drives the palette and line store RAM ports.
module pup_seq #(
    parameter int SRC_WIDTH  = 320,
    parameter int SRC_HEIGHT = 200,
    parameter int SCALE      = 5,
    parameter int LX_W       = $clog2(SRC_WIDTH)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  pup_pkg::cfg_t                 cfg,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  pup_pkg::in_item_t             item,
    output logic                          pal_we,
    output logic [pup_pkg::IDX_W-1:0]     pal_waddr,
    output logic [pup_pkg::COLOR_W-1:0]   pal_wdata,
    output logic [pup_pkg::IDX_W-1:0]     pal_raddr,
    input  logic [pup_pkg::COLOR_W-1:0]   pal_rdata,
    output logic                          line_we,
    output logic [LX_W-1:0]               line_waddr,
    output logic [pup_pkg::PV_W-1:0]      line_wdata,
    output logic [LX_W-1:0]               line_raddr,
    input  logic [pup_pkg::PV_W-1:0]      line_rdata,
    output pup_pkg::emit_req_t            emit,
    input  logic [pup_pkg::ADDR_W-1:0]    addr_in,
    input  logic [pup_pkg::LANE_W-1:0]    lane_in,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [pup_pkg::DATA_W-1:0]    pixel_data,
    output logic [pup_pkg::ADDR_W-1:0]    word_address,
    output logic                          half_out,
    output logic [pup_pkg::LANE_W-1:0]    lane
);

    localparam int OX_LIMIT = SRC_WIDTH * SCALE + 8;
    localparam int OX_W     = $clog2(OX_LIMIT);
    localparam int RS       = OX_W + 3;
    localparam int RM       = (2 ** RS + SCALE - 1) / SCALE;
    localparam int MW       = OX_W + RS;
    localparam int RW888    = (SRC_WIDTH * SCALE + 3) / 4;
    localparam int RW565    = (SRC_WIDTH * SCALE + 7) / 8;
    localparam int RW_W     = $clog2(RW888 + 1);
    localparam int CW       = (RW_W > pup_pkg::OW_W) ? RW_W : pup_pkg::OW_W;
    localparam int HW       = ($clog2(SRC_HEIGHT + 1) > pup_pkg::ROW_W) ?
                              $clog2(SRC_HEIGHT + 1) : pup_pkg::ROW_W;
    localparam int XW       = ($clog2(SRC_WIDTH + 1) > pup_pkg::PX_W) ?
                              $clog2(SRC_WIDTH + 1) : pup_pkg::PX_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_GATHER,
        ST_HOLD
    } state_t;

    state_t                           state_reg,     state_next;
    logic [OX_W-1:0]                  ox_reg,        ox_next;
    logic [pup_pkg::PC_W-1:0]         issue_cnt_reg, issue_cnt_next;
    logic [pup_pkg::PC_W-1:0]         pack_cnt_reg,  pack_cnt_next;
    logic [pup_pkg::PC_W-1:0]         pph_reg,       pph_next;
    logic                             fmt_reg,       fmt_next;
    logic                             half_reg,      half_next;
    logic [LX_W-1:0]                  sx_reg,        sx_next;
    logic                             v_sx_reg,      v_sx_next;
    logic                             v_line_reg,    v_line_next;
    logic                             v_pal_reg,     v_pal_next;
    logic [pup_pkg::DATA_W-1:0]       data_reg,      data_next;
    logic                             m_valid_reg,   m_valid_next;
    logic [pup_pkg::DATA_W-1:0]       pix_out_reg,   pix_out_next;
    logic [pup_pkg::ADDR_W-1:0]       addr_out_reg,  addr_out_next;
    logic                             half_out_reg,  half_out_next;
    logic [pup_pkg::LANE_W-1:0]       lane_out_reg,  lane_out_next;

    logic                     accept;
    logic [HW-1:0]            rows_eff;
    logic [CW-1:0]            words_per_row;
    logic                     emit_ok;
    logic                     start;
    logic [OX_W-1:0]          base_ox;
    logic [MW-1:0]            prod;
    logic [OX_W-1:0]          sx_full;
    logic [pup_pkg::DATA_W-1:0] data_shift;
    logic                     pack_last;
    logic                     out_free;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    // Write paths go straight to the RAMs
    assign pal_we     = accept && (item.command == pup_pkg::CMD_PAL_WR);
    assign pal_waddr  = item.entry_index;
    assign pal_wdata  = {item.red, item.green, item.blue};
    assign line_we    = accept && (item.command == pup_pkg::CMD_LINE_WR)
                        && (XW'(item.pixel_x) < XW'(SRC_WIDTH));
    assign line_waddr = LX_W'(item.pixel_x);
    assign line_wdata = item.pixel_value;

    // Read chain: source column -> palette index -> color
    assign line_raddr = sx_reg;
    assign pal_raddr  = line_rdata;

    always_comb
    begin
        if (cfg.rows_in_use == '0 || HW'(cfg.rows_in_use) > HW'(SRC_HEIGHT))
        begin
            rows_eff = HW'(SRC_HEIGHT);
        end
        else
        begin
            rows_eff = HW'(cfg.rows_in_use);
        end
        words_per_row = (cfg.fmt == pup_pkg::FMT_RGB565) ? CW'(RW565) : CW'(RW888);
        emit_ok = (HW'(item.src_row) < rows_eff)
                  && ({1'b0, item.rep_row} < 4'(SCALE))
                  && (CW'(item.out_word) < words_per_row);
        start   = accept && (item.command == pup_pkg::CMD_EMIT) && emit_ok;

        if (cfg.fmt == pup_pkg::FMT_RGB565)
        begin
            base_ox = OX_W'({item.out_word, 3'b000}) + OX_W'({item.half_select, 2'b00});
        end
        else
        begin
            base_ox = OX_W'({item.out_word, 2'b00}) + OX_W'({item.half_select, 1'b0});
        end

        emit.start    = start;
        emit.fmt      = cfg.fmt;
        emit.src_row  = item.src_row;
        emit.rep_row  = item.rep_row;
        emit.out_word = item.out_word;

        // Output column to source column by reciprocal multiply, clamp to row
        prod    = MW'(ox_reg) * MW'(RM);
        sx_full = prod[MW-1:RS];
        if (sx_full >= OX_W'(SRC_WIDTH))
        begin
            sx_next = LX_W'(SRC_WIDTH - 1);
        end
        else
        begin
            sx_next = LX_W'(sx_full);
        end

        // New pixel enters at the top, earlier pixels move down
        if (fmt_reg == pup_pkg::FMT_RGB565)
        begin
            data_shift = {pup_pkg::to_rgb565(pal_rdata), data_reg[63:16]};
        end
        else
        begin
            data_shift = {8'h00, pal_rdata, data_reg[63:32]};
        end

        pack_last = v_pal_reg && (pack_cnt_reg == pph_reg - 3'd1);
        out_free  = !m_valid_reg || m_tready;

        state_next     = state_reg;
        ox_next        = ox_reg;
        issue_cnt_next = issue_cnt_reg;
        pack_cnt_next  = pack_cnt_reg;
        pph_next       = pph_reg;
        fmt_next       = fmt_reg;
        half_next      = half_reg;
        v_sx_next      = 1'b0;
        v_line_next    = 1'b0;
        v_pal_next     = 1'b0;
        data_next      = data_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        pix_out_next   = pix_out_reg;
        addr_out_next  = addr_out_reg;
        half_out_next  = half_out_reg;
        lane_out_next  = lane_out_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next     = ST_GATHER;
                    ox_next        = base_ox;
                    issue_cnt_next = '0;
                    pack_cnt_next  = '0;
                    fmt_next       = cfg.fmt;
                    half_next      = item.half_select;
                    pph_next       = (cfg.fmt == pup_pkg::FMT_RGB565) ?
                                     pup_pkg::PPH_565 : pup_pkg::PPH_XRGB;
                end
            end
            ST_GATHER:
            begin
                if (issue_cnt_reg != pph_reg)
                begin
                    ox_next        = ox_reg + OX_W'(1);
                    issue_cnt_next = issue_cnt_reg + 3'd1;
                    v_sx_next      = 1'b1;
                end
                v_line_next = v_sx_reg;
                v_pal_next  = v_line_reg;
                if (v_pal_reg)
                begin
                    data_next     = data_shift;
                    pack_cnt_next = pack_cnt_reg + 3'd1;
                end
                if (pack_last)
                begin
                    if (out_free)
                    begin
                        state_next    = ST_IDLE;
                        m_valid_next  = 1'b1;
                        pix_out_next  = data_shift;
                        addr_out_next = addr_in;
                        half_out_next = half_reg;
                        lane_out_next = lane_in;
                    end
                    else
                    begin
                        state_next = ST_HOLD;
                    end
                end
            end
            ST_HOLD:
            begin
                if (out_free)
                begin
                    state_next    = ST_IDLE;
                    m_valid_next  = 1'b1;
                    pix_out_next  = data_reg;
                    addr_out_next = addr_in;
                    half_out_next = half_reg;
                    lane_out_next = lane_in;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            issue_cnt_reg <= '0;
            pack_cnt_reg  <= '0;
            pph_reg       <= pup_pkg::PPH_XRGB;
            v_sx_reg      <= 1'b0;
            v_line_reg    <= 1'b0;
            v_pal_reg     <= 1'b0;
            m_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            issue_cnt_reg <= issue_cnt_next;
            pack_cnt_reg  <= pack_cnt_next;
            pph_reg       <= pph_next;
            v_sx_reg      <= v_sx_next;
            v_line_reg    <= v_line_next;
            v_pal_reg     <= v_pal_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ox_reg       <= ox_next;
        fmt_reg      <= fmt_next;
        half_reg     <= half_next;
        sx_reg       <= sx_next;
        data_reg     <= data_next;
        pix_out_reg  <= pix_out_next;
        addr_out_reg <= addr_out_next;
        half_out_reg <= half_out_next;
        lane_out_reg <= lane_out_next;
    end

    assign m_tvalid     = m_valid_reg;
    assign pixel_data   = pix_out_reg;
    assign word_address = addr_out_reg;
    assign half_out     = half_out_reg;
    assign lane         = lane_out_reg;

endmodule

### hdl/palette_upscale_packer.sv
// Top level of the palette upscale packer: configuration registers, stream
// ports, palette and line store RAMs. Depends on pup_pkg, pup_ram, pup_addr, pup_seq.
//
//  channel   | direction | handshake          | payload
//  ----------+-----------+--------------------+-----------------------------------
//  config    | in        | cfg_we             | cfg_index, cfg_data
//  s (items) | in        | s_tvalid/s_tready  | s_tuser command, s_tdata fields
//  m (words) | out       | m_tvalid/m_tready  | m_tdata pixels+address, m_tuser half+lane
//
// Palette writes, line store writes and ignored items leave s_tready high.
// An emit that yields a result holds s_tready low until its half word of PPH pixels
// (PPH = 2 for XRGB8888, 4 for RGB565) is registered: one pixel per cycle flows through
// the line store read port and then the palette read port, followed by packing.
// A finished half word waits in the output register while input goes on; the
// next emit stalls only if that register is still full when it completes.
// Reset clears control and configuration; RAM contents stay undefined until written.
module palette_upscale_packer #(
    parameter int SRC_WIDTH  = 320,
    parameter int SRC_HEIGHT = 200,
    parameter int SCALE      = 5
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [pup_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [pup_pkg::CFG_W-1:0]       cfg_data,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // entry_index, red, green, blue, pixel_x, pixel_value, src_row, rep_row,
    // out_word, half_select (lowest first)
    input  logic [pup_pkg::S_TDATA_W-1:0]   s_tdata,
    // command
    input  logic [pup_pkg::S_TUSER_W-1:0]   s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // pixel_data, word_address (lowest first)
    output logic [pup_pkg::M_TDATA_W-1:0]   m_tdata,
    // half_out, lane (lowest first)
    output logic [pup_pkg::M_TUSER_W-1:0]   m_tuser
);

    localparam int LX_W = $clog2(SRC_WIDTH);

    logic                          fmt_reg,    fmt_next;
    logic [pup_pkg::STRIDE_W-1:0]  stride_reg, stride_next;
    logic [pup_pkg::ROWS_W-1:0]    rows_reg,   rows_next;

    pup_pkg::cfg_t      cfg;
    pup_pkg::in_item_t  item;
    pup_pkg::emit_req_t emit;

    logic                          pal_we;
    logic [pup_pkg::IDX_W-1:0]     pal_waddr;
    logic [pup_pkg::COLOR_W-1:0]   pal_wdata;
    logic [pup_pkg::IDX_W-1:0]     pal_raddr;
    logic [pup_pkg::COLOR_W-1:0]   pal_rdata;
    logic                          line_we;
    logic [LX_W-1:0]               line_waddr;
    logic [pup_pkg::PV_W-1:0]      line_wdata;
    logic [LX_W-1:0]               line_raddr;
    logic [pup_pkg::PV_W-1:0]      line_rdata;
    logic [pup_pkg::ADDR_W-1:0]    addr_calc;
    logic [pup_pkg::LANE_W-1:0]    lane_calc;
    logic [pup_pkg::DATA_W-1:0]    pixel_data;
    logic [pup_pkg::ADDR_W-1:0]    word_address;
    logic                          half_out;
    logic [pup_pkg::LANE_W-1:0]    lane;

    // Configuration decode; an index past the list is dropped
    always_comb
    begin
        fmt_next    = fmt_reg;
        stride_next = stride_reg;
        rows_next   = rows_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                pup_pkg::CFG_FORMAT: fmt_next    = cfg_data[0];
                pup_pkg::CFG_STRIDE: stride_next = cfg_data;
                pup_pkg::CFG_ROWS:   rows_next   = cfg_data[pup_pkg::ROWS_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg    <= pup_pkg::FMT_XRGB8888;
            stride_reg <= '0;
            rows_reg   <= '0;
        end
        else
        begin
            fmt_reg    <= fmt_next;
            stride_reg <= stride_next;
            rows_reg   <= rows_next;
        end
    end

    assign cfg.fmt          = fmt_reg;
    assign cfg.stride_bytes = stride_reg;
    assign cfg.rows_in_use  = rows_reg;

    // Unpack the input item
    assign item.command     = s_tuser;
    assign item.entry_index = s_tdata[7:0];
    assign item.red         = s_tdata[15:8];
    assign item.green       = s_tdata[23:16];
    assign item.blue        = s_tdata[31:24];
    assign item.pixel_x     = s_tdata[40:32];
    assign item.pixel_value = s_tdata[48:41];
    assign item.src_row     = s_tdata[56:49];
    assign item.rep_row     = s_tdata[59:57];
    assign item.out_word    = s_tdata[68:60];
    assign item.half_select = s_tdata[69];

    // Palette: 256 RGB888 entries
    pup_ram #(
        .DEPTH (256),
        .WIDTH (pup_pkg::COLOR_W),
        .AW    (pup_pkg::IDX_W)
    ) u_palette (
        .clk   (clk),
        .we    (pal_we),
        .waddr (pal_waddr),
        .wdata (pal_wdata),
        .raddr (pal_raddr),
        .rdata (pal_rdata)
    );

    // Line store: one source row of palette indexes
    pup_ram #(
        .DEPTH (SRC_WIDTH),
        .WIDTH (pup_pkg::PV_W),
        .AW    (LX_W)
    ) u_line (
        .clk   (clk),
        .we    (line_we),
        .waddr (line_waddr),
        .wdata (line_wdata),
        .raddr (line_raddr),
        .rdata (line_rdata)
    );

    // Address and lane run alongside the pixel gather
    pup_addr #(
        .SRC_WIDTH (SRC_WIDTH),
        .SCALE     (SCALE)
    ) u_addr (
        .clk          (clk),
        .req          (emit),
        .stride_bytes (stride_reg),
        .word_address (addr_calc),
        .lane         (lane_calc)
    );

    pup_seq #(
        .SRC_WIDTH  (SRC_WIDTH),
        .SRC_HEIGHT (SRC_HEIGHT),
        .SCALE      (SCALE),
        .LX_W       (LX_W)
    ) u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .item         (item),
        .pal_we       (pal_we),
        .pal_waddr    (pal_waddr),
        .pal_wdata    (pal_wdata),
        .pal_raddr    (pal_raddr),
        .pal_rdata    (pal_rdata),
        .line_we      (line_we),
        .line_waddr   (line_waddr),
        .line_wdata   (line_wdata),
        .line_raddr   (line_raddr),
        .line_rdata   (line_rdata),
        .emit         (emit),
        .addr_in      (addr_calc),
        .lane_in      (lane_calc),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .pixel_data   (pixel_data),
        .word_address (word_address),
        .half_out     (half_out),
        .lane         (lane)
    );

    // Pack the result item, zero fill to whole bytes
    assign m_tdata = {2'b00, word_address, pixel_data};
    assign m_tuser = {lane, half_out};

endmodule
